>>> hdl/spdb_pkg.sv
// Shared types, constants and a helper function of the spectrum dB/phase frame history.
// Depends on nothing; every other file imports it.
package spdb_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int LOG_FRAC     = 20;
	localparam int SQRT_STEPS   = 32;
	localparam int NORM_STEPS   = 6;
	localparam int CW           = 36;

	// atan(2^-i) with 2^31 = pi
	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	// 20*log10(2) in Q.24
	localparam logic [26:0] DB_K = 27'd101008905;

	typedef enum logic [1:0] {
		OP_WRITE       = 2'd0,
		OP_READ_AGE    = 2'd1,
		OP_READ_NEWEST = 2'd2,
		OP_CLEAR       = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RUN, S_WRITE, S_OLDEST, S_SLOT, S_ADDR, S_MEM, S_RESULT
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [9:0]         bin_index;
		logic signed [31:0] bin_real;
		logic signed [31:0] bin_imag;
		logic [7:0]         frame_age;
		logic [62:0]        frame_start_sample;
	} in_word_t;

	typedef struct packed {
		logic               found;
		logic signed [15:0] magnitude_db;
		logic signed [15:0] phase_angle;
		logic [62:0]        read_frame_sample;
		logic [8:0]         frames_held;
		logic [62:0]        oldest_sample;
		logic [62:0]        newest_sample;
	} out_word_t;

	typedef struct packed {
		logic               valid;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]        z;
	} cordic_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] s;
		logic [63:0] r;
	} sqrt_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] v;
		logic [5:0]  cnt;
	} norm_t;

	typedef struct packed {
		logic                valid;
		logic [5:0]          p;
		logic [30:0]         y;
		logic [LOG_FRAC-1:0] frac;
	} log_t;

	// log2 in Q.LOG_FRAC, truncated; used for elaboration-time constants
	function automatic logic [63:0] log2_q_const(input logic [63:0] v);
		logic [63:0] y;
		logic [63:0] res;
		int p;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (v[i]) p = i;
		y = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
		res = 64'(p) << LOG_FRAC;
		for (int i = LOG_FRAC - 1; i >= 0; i--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				res = res + (64'd1 << i);
				y = y >> 1;
			end
		end
		return res;
	endfunction

endpackage

>>> hdl/spdb_ifs.sv
// Valid/ready channel interfaces for request and response words.
// Depends on spdb_pkg.
interface spdb_in_if import spdb_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface spdb_out_if import spdb_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hdl/spectrum_polar_db_frame_history.sv
// Top level: polar/dB conversion cell rows, bin and frame-sample stores, ring control.
// Depends on spdb_pkg, spdb_ifs and the spdb_*_cell modules.
//
// Takes one request word at a time. A bin write runs through a row of 32 square-root
// cells, 6 normalize cells and 20 log2 squaring cells (a 24-cell CORDIC row runs beside
// them) before its store write and response word; a commit that drops the oldest frame
// adds a step that reloads the oldest sample. Reads go through slot, address and store
// read steps to the output register; clear and a write beyond Nyquist go straight to it.
// The next request is taken in the cycle after the response is loaded.
// The response sits in an output register, so the next request is taken while it waits.
// Bin data of a frame slot are unknown until written; nothing is cleared after reset.
module spectrum_polar_db_frame_history import spdb_pkg::*; #(
	parameter int FFT_POINTS     = 1024,
	parameter int HISTORY_FRAMES = 256
) (
	input logic               clk,
	input logic               arst_n,
	spdb_in_if.sink           req,
	spdb_out_if.source        rsp
);
	localparam int BIN_COUNT = FFT_POINTS / 2 + 1;
	localparam int DEPTH     = HISTORY_FRAMES * BIN_COUNT;
	localparam int AW        = $clog2(DEPTH);
	localparam int SW        = $clog2(HISTORY_FRAMES);
	localparam int HW        = $clog2(HISTORY_FRAMES + 1);
	localparam int SLW       = SW + 2;
	localparam logic [63:0] EPS   = ((64'(FFT_POINTS) << 40) + 64'd500000) / 64'd1000000;
	localparam logic [63:0] LOG_N = log2_q_const(64'(FFT_POINTS) << 40);

	state_t state_q, state_d;
	in_word_t in_q;
	logic accept, launch_q, found_q, out_valid_q, out_free;
	logic [SW-1:0] ws_q, ws_inc, slot_q, slot_d, smp_addr;
	logic [HW-1:0] held_q;
	logic [62:0] oldest_q, newest_q;
	logic [AW-1:0] addr_q;
	logic [SW-1:0] addr_base;
	logic bin_ok_in, bin_ok_q, is_edge, commit, full, ok_d, is_read;
	logic [SLW-1:0] age_sum, age_slot;
	out_word_t out_q;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign bin_ok_in = ({22'b0, req.data.bin_index} < 32'(BIN_COUNT));
	assign bin_ok_q  = ({22'b0, in_q.bin_index} < 32'(BIN_COUNT));
	assign is_edge   = (in_q.bin_index == 10'd0) ||
		({22'b0, in_q.bin_index} == 32'(BIN_COUNT - 1));
	assign commit    = ({22'b0, in_q.bin_index} == 32'(BIN_COUNT - 1));
	assign full      = (held_q == HW'(HISTORY_FRAMES));
	assign ws_inc    = (ws_q == SW'(HISTORY_FRAMES - 1)) ? '0 : ws_q + 1'b1;
	assign is_read   = (in_q.operation == OP_READ_AGE) || (in_q.operation == OP_READ_NEWEST);
	assign out_free  = !out_valid_q || rsp.ready;

	// ---------------- magnitude path ----------------
	logic [31:0] are, aim;
	logic [63:0] sq_re_s1, sq_im_s1, s_s2;
	logic v_s1, v_s2;

	assign are = in_q.bin_real[31] ? 32'(~in_q.bin_real + 32'sd1) : 32'(in_q.bin_real);
	assign aim = in_q.bin_imag[31] ? 32'(~in_q.bin_imag + 32'sd1) : 32'(in_q.bin_imag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= launch_q;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (launch_q) begin
			sq_re_s1 <= are * are;
			sq_im_s1 <= aim * aim;
		end
		if (v_s1) s_s2 <= sq_re_s1 + sq_im_s1;
	end

	sqrt_t sq [SQRT_STEPS + 1];
	assign sq[0] = '{valid: v_s2, s: s_s2, r: 64'd0};

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		spdb_sqrt_cell #(.STEP(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .cell_in(sq[i]), .cell_out(sq[i + 1])
		);
	end

	// amplitude: 2*sqrt rounded by remainder, or |re| on the edge bins
	logic [32:0] amp;
	logic [63:0] x_q;
	logic x_valid_q;

	assign amp = is_edge ? {1'b0, are} :
		({sq[SQRT_STEPS].r[31:0], 1'b0} + 33'(sq[SQRT_STEPS].s > sq[SQRT_STEPS].r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) x_valid_q <= 1'b0;
		else x_valid_q <= sq[SQRT_STEPS].valid;
	end

	always_ff @(posedge clk) begin
		if (sq[SQRT_STEPS].valid) x_q <= (64'(amp) << 16) + EPS;
	end

	norm_t nm [NORM_STEPS + 1];
	assign nm[0] = '{valid: x_valid_q, v: x_q, cnt: 6'd0};

	for (genvar i = 0; i < NORM_STEPS; i++) begin : g_norm
		spdb_norm_cell #(.SH(32 >> i)) u_cell (
			.clk(clk), .arst_n(arst_n), .cell_in(nm[i]), .cell_out(nm[i + 1])
		);
	end

	log_t lg [LOG_FRAC + 1];
	assign lg[0] = '{valid: nm[NORM_STEPS].valid, p: 6'd63 - nm[NORM_STEPS].cnt,
		y: nm[NORM_STEPS].v[63:33], frac: '0};

	for (genvar i = 0; i < LOG_FRAC; i++) begin : g_log
		spdb_log_cell #(.FBIT(LOG_FRAC - 1 - i)) u_cell (
			.clk(clk), .arst_n(arst_n), .cell_in(lg[i]), .cell_out(lg[i + 1])
		);
	end

	// dB = (log2 X - log2 N*2^40) * 20log10(2), rounded away from zero, saturated
	logic signed [27:0] lval;
	logic [26:0] labs;
	logic [53:0] dbm_s1;
	logic neg_s1, db_v_s1, db_v_s2;
	logic [17:0] rr, rneg;
	logic [53:0] rsum;
	logic [15:0] db_s2;

	assign lval = signed'({2'b0, lg[LOG_FRAC].p, lg[LOG_FRAC].frac}) - signed'(28'(LOG_N));
	assign labs = lval[27] ? 27'(-lval) : lval[26:0];
	assign rsum = dbm_s1 + (54'd1 << 35);
	assign rr   = rsum[53:36];
	assign rneg = 18'd0 - rr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_v_s1 <= 1'b0;
			db_v_s2 <= 1'b0;
		end else begin
			db_v_s1 <= lg[LOG_FRAC].valid;
			db_v_s2 <= db_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (lg[LOG_FRAC].valid) begin
			dbm_s1 <= labs * DB_K;
			neg_s1 <= lval[27];
		end
		if (db_v_s1) begin
			if (neg_s1) db_s2 <= (rr > 18'd32768) ? 16'h8000 : rneg[15:0];
			else db_s2 <= (rr > 18'd32767) ? 16'h7FFF : rr[15:0];
		end
	end

	// ---------------- phase path ----------------
	logic signed [CW-1:0] re_x, im_x;
	cordic_t cd_head_q;
	logic cd_head_v_q;
	cordic_t cd [CORDIC_STEPS + 1];
	logic [31:0] z_round;
	logic [15:0] phase;

	assign re_x = CW'(in_q.bin_real);
	assign im_x = CW'(in_q.bin_imag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cd_head_v_q <= 1'b0;
		else cd_head_v_q <= launch_q;
	end

	// pre-rotate by pi into the right half plane
	always_ff @(posedge clk) begin
		if (launch_q) begin
			cd_head_q.valid <= 1'b1;
			cd_head_q.x <= in_q.bin_real[31] ? -re_x : re_x;
			cd_head_q.y <= in_q.bin_real[31] ? -im_x : im_x;
			cd_head_q.z <= in_q.bin_real[31] ? 32'h8000_0000 : 32'd0;
		end
	end

	assign cd[0] = '{valid: cd_head_v_q, x: cd_head_q.x, y: cd_head_q.y, z: cd_head_q.z};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		spdb_cordic_cell #(.IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .cell_in(cd[i]), .cell_out(cd[i + 1])
		);
	end

	assign z_round = cd[CORDIC_STEPS].z + 32'h8000;
	always_comb begin
		if (is_edge) phase = 16'd0;
		else if (in_q.bin_imag == 32'sd0) phase = in_q.bin_real[31] ? 16'h8000 : 16'd0;
		else phase = z_round[31:16];
	end

	// ---------------- stores ----------------
	logic [15:0] mag_mem [DEPTH];
	logic [15:0] ph_mem [DEPTH];
	logic [62:0] smp_mem [HISTORY_FRAMES];
	logic [15:0] mag_rd_q, ph_rd_q;
	logic [62:0] smp_rd_q;

	assign smp_addr  = (state_q == S_WRITE) ? ws_inc : slot_q;
	assign addr_base = (state_q == S_RUN) ? ws_q : slot_q;

	always_ff @(posedge clk) begin
		if (state_q == S_RUN || state_q == S_ADDR)
			addr_q <= AW'(AW'(addr_base) * AW'(BIN_COUNT)) + AW'(in_q.bin_index);
		if (state_q == S_WRITE) begin
			mag_mem[addr_q] <= db_s2;
			ph_mem[addr_q]  <= phase;
		end
		mag_rd_q <= mag_mem[addr_q];
		ph_rd_q  <= ph_mem[addr_q];
		if (state_q == S_WRITE && commit) smp_mem[ws_q] <= in_q.frame_start_sample;
		smp_rd_q <= smp_mem[smp_addr];
	end

	// ---------------- read slot ----------------
	assign age_sum  = SLW'(ws_q) + SLW'(HISTORY_FRAMES) - SLW'(held_q) + SLW'(in_q.frame_age);
	assign age_slot = (age_sum >= SLW'(HISTORY_FRAMES)) ? age_sum - SLW'(HISTORY_FRAMES) : age_sum;

	always_comb begin
		if (in_q.operation == OP_READ_AGE) begin
			ok_d   = ({24'b0, in_q.frame_age} < 32'(held_q));
			slot_d = age_slot[SW-1:0];
		end else begin
			ok_d   = (held_q != '0);
			slot_d = (ws_q == '0) ? SW'(HISTORY_FRAMES - 1) : ws_q - 1'b1;
		end
	end

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (op_t'(req.data.operation))
						OP_WRITE: state_d = bin_ok_in ? S_RUN : S_RESULT;
						OP_CLEAR: state_d = S_RESULT;
						default:  state_d = S_SLOT;
					endcase
				end
			end
			S_RUN:    if (db_v_s2) state_d = S_WRITE;
			S_WRITE:  state_d = (commit && full) ? S_OLDEST : S_RESULT;
			S_OLDEST: state_d = S_RESULT;
			S_SLOT:   state_d = S_ADDR;
			S_ADDR:   state_d = S_MEM;
			S_MEM:    state_d = S_RESULT;
			S_RESULT: if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= 1'b0;
			found_q     <= 1'b0;
			ws_q        <= '0;
			held_q      <= '0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept && (req.data.operation == OP_WRITE) && bin_ok_in;
			if (accept) begin
				found_q <= ((req.data.operation == OP_WRITE) && bin_ok_in) ||
					(req.data.operation == OP_CLEAR);
				if (req.data.operation == OP_CLEAR) begin
					ws_q   <= '0;
					held_q <= '0;
				end
			end
			if (state_q == S_SLOT) begin
				found_q <= ok_d && bin_ok_q;
				slot_q  <= slot_d;
			end
			// commit the frame: advance the ring
			if (state_q == S_WRITE && commit) begin
				ws_q <= ws_inc;
				if (!full) held_q <= held_q + 1'b1;
			end
			if (state_q == S_RESULT && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// request capture and oldest/newest sample tracking
	always_ff @(posedge clk) begin
		if (accept) in_q <= req.data;
		if (state_q == S_WRITE && commit) begin
			newest_q <= in_q.frame_start_sample;
			if (held_q == '0) oldest_q <= in_q.frame_start_sample;
		end
		if (state_q == S_OLDEST) oldest_q <= smp_rd_q;
	end

	// response word
	always_ff @(posedge clk) begin
		if (state_q == S_RESULT && out_free) begin
			out_q.found             <= found_q;
			out_q.magnitude_db      <= (is_read && found_q) ? mag_rd_q : 16'd0;
			out_q.phase_angle       <= (is_read && found_q) ? ph_rd_q : 16'd0;
			out_q.read_frame_sample <= (is_read && found_q) ? smp_rd_q : 63'd0;
			out_q.frames_held       <= 9'(held_q);
			out_q.oldest_sample     <= (held_q != '0) ? oldest_q : 63'd0;
			out_q.newest_sample     <= (held_q != '0) ? newest_q : 63'd0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// ---------------- assertions ----------------
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(HISTORY_FRAMES))
		else $error("held count beyond ring size");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		ws_q <= SW'(HISTORY_FRAMES - 1))
		else $error("write slot out of range");

	a_db_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		db_v_s2 |-> (state_q == S_RUN))
		else $error("magnitude finished outside a bin write");

	a_phase_first: assert property (@(posedge clk) disable iff (!arst_n)
		db_v_s2 |-> !(cd_head_v_q || v_s1 || v_s2))
		else $error("magnitude done while a new conversion is starting");

	a_commit_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && commit) |=> (ws_q == $past(ws_inc)))
		else $error("write slot did not advance on commit");
endmodule

>>> hdl/spdb_sqrt_cell.sv
// One bit of a restoring integer square root; cells are chained.
// Depends on spdb_pkg.
module spdb_sqrt_cell import spdb_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  sqrt_t cell_in,
	output sqrt_t cell_out
);
	localparam logic [63:0] BITV = 64'd1 << (62 - 2 * STEP);

	logic [63:0] trial;
	logic        take;
	logic        valid_q;
	logic [63:0] s_q, r_q;

	assign trial = cell_in.r + BITV;
	assign take  = cell_in.s >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= cell_in.valid;
	end

	// subtract the trial value when it fits
	always_ff @(posedge clk) begin
		if (cell_in.valid) begin
			s_q <= take ? cell_in.s - trial : cell_in.s;
			r_q <= take ? (cell_in.r >> 1) + BITV : cell_in.r >> 1;
		end
	end

	assign cell_out = '{valid: valid_q, s: s_q, r: r_q};
endmodule

>>> hdl/spdb_norm_cell.sv
// One step of the leading-one search: shift left when the top SH bits are clear.
// Depends on spdb_pkg.
module spdb_norm_cell import spdb_pkg::*; #(
	parameter int SH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  norm_t cell_in,
	output norm_t cell_out
);
	logic        zero_top;
	logic        valid_q;
	logic [63:0] v_q;
	logic [5:0]  cnt_q;

	assign zero_top = (cell_in.v[63 -: SH] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= cell_in.valid;
	end

	always_ff @(posedge clk) begin
		if (cell_in.valid) begin
			v_q   <= zero_top ? cell_in.v << SH : cell_in.v;
			cnt_q <= zero_top ? cell_in.cnt + 6'(SH) : cell_in.cnt;
		end
	end

	assign cell_out = '{valid: valid_q, v: v_q, cnt: cnt_q};
endmodule

>>> hdl/spdb_log_cell.sv
// One fraction bit of log2 by squaring the normalized mantissa.
// Depends on spdb_pkg.
module spdb_log_cell import spdb_pkg::*; #(
	parameter int FBIT = LOG_FRAC - 1
) (
	input  logic clk,
	input  logic arst_n,
	input  log_t cell_in,
	output log_t cell_out
);
	logic [61:0]         sq;
	logic [31:0]         t;
	logic                valid_q;
	logic [5:0]          p_q;
	logic [30:0]         y_q;
	logic [LOG_FRAC-1:0] frac_q;

	assign sq = cell_in.y * cell_in.y;
	assign t  = sq[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= cell_in.valid;
	end

	// square >= 2 sets this bit and halves the mantissa
	always_ff @(posedge clk) begin
		if (cell_in.valid) begin
			p_q    <= cell_in.p;
			y_q    <= t[31] ? t[31:1] : t[30:0];
			frac_q <= cell_in.frac | (LOG_FRAC'(t[31]) << FBIT);
		end
	end

	assign cell_out = '{valid: valid_q, p: p_q, y: y_q, frac: frac_q};
endmodule

>>> hdl/spdb_cordic_cell.sv
// One vectoring CORDIC micro-rotation, floor shifts, angle with 2^31 = pi.
// Depends on spdb_pkg.
module spdb_cordic_cell import spdb_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cordic_t cell_in,
	output cordic_t cell_out
);
	logic signed [CW-1:0] xi, yi, dx, dy;
	logic                 up;
	logic                 valid_q;
	logic signed [CW-1:0] x_q, y_q;
	logic [31:0]          z_q;

	assign xi = cell_in.x;
	assign yi = cell_in.y;
	assign dx = yi >>> IDX;
	assign dy = xi >>> IDX;
	assign up = yi > 0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else valid_q <= cell_in.valid;
	end

	always_ff @(posedge clk) begin
		if (cell_in.valid) begin
			x_q <= up ? xi + dx : xi - dx;
			y_q <= up ? yi - dy : yi + dy;
			z_q <= up ? cell_in.z + ATAN_TAB[IDX] : cell_in.z - ATAN_TAB[IDX];
		end
	end

	assign cell_out = '{valid: valid_q, x: x_q, y: y_q, z: z_q};
endmodule
